// ===== sv/varint_header_parser_macros.svh =====
// assertion helpers shared by the checker
`ifndef VARINT_HEADER_PARSER_MACROS_SVH
`define VARINT_HEADER_PARSER_MACROS_SVH

// same-cycle implication, off while reset is low
`define VHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vhp: implication check failed");

// next-cycle implication, off while reset is low
`define VHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vhp: next-cycle check failed");

`endif

// ===== sv/vhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vhp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_KNOWN_TYPE = 1'b1;

    localparam logic [7:0] MAGIC_RESET = 8'd94;
    localparam logic [7:0] HKT_RESET   = 8'd7;

    // last varint byte index that still carries seven payload bits
    localparam logic [3:0] VARINT_LAST_FULL = 4'd8;

    typedef enum logic [2:0] {
        PH_MAGIC  = 3'd0,
        PH_KEY    = 3'd1,
        PH_GROUP  = 3'd2,
        PH_PTYPE  = 3'd3,
        PH_PVALUE = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BASE  = 2'd0,
        KIND_PAIR  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_MAGIC = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in;

    typedef struct packed {
        t_kind        result_kind;
        logic [31:0]  body_size;
        logic [31:0]  type_id;
        logic [31:0]  request_id;
        logic [31:0]  extra_count;
        logic [63:0]  pair_type;
        logic [63:0]  pair_value;
        logic         pair_known;
        logic [31:0]  header_length;
        t_err         error_code;
        logic         last_of_header;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // up to two results per byte; the second is used only with the first
    typedef struct packed {
        logic    wr0;
        logic    wr1;
        t_result res0;
        t_result res1;
    } t_qwrite;

endpackage
`default_nettype wire

// ===== sv/vhp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vhp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire vhp_pkg::t_qwrite i_wr,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic                  o_room2,
    output vhp_pkg::t_result      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(DEPTH - 2);

    vhp_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0] r_rp, r_wp, n_rp, n_wp;
    logic [PTR_W-1:0] w_wp1, w_wp2;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop_ok;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        w_pop_ok = i_pop && (r_count != '0);
        w_wp1    = ptr_inc(r_wp);
        w_wp2    = ptr_inc(w_wp1);
        n_wp     = i_wr.wr1 ? w_wp2 : (i_wr.wr0 ? w_wp1 : r_wp);
        n_rp     = w_pop_ok ? ptr_inc(r_rp) : r_rp;
        n_count  = r_count + CNT_W'(i_wr.wr0) + CNT_W'(i_wr.wr1) - CNT_W'(w_pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr0) begin
            r_mem[r_wp] <= i_wr.res0;
        end
        if (i_wr.wr1) begin
            r_mem[w_wp1] <= i_wr.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_count <= '0;
        end else begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_count <= n_count;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_room2 = (r_count <= CNT_ROOM2);
    assign o_head  = r_mem[r_rp];

endmodule
`default_nettype wire

// ===== sv/vhp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vhp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire vhp_pkg::t_in     i_in,
    input  wire vhp_pkg::t_cfg_wr i_cfg,
    output vhp_pkg::t_qwrite      o_wr
);

    vhp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_magic, r_hkt;
    logic [7:0]  r_group_key, n_group_key;
    logic [1:0]  r_value_index, n_value_index;
    logic [3:0]  r_byte_index, n_byte_index;
    logic [31:0] r_word_acc, n_word_acc;
    logic [31:0] r_body_size, n_body_size;
    logic [31:0] r_type_id, n_type_id;
    logic [31:0] r_request_id, n_request_id;
    logic [31:0] r_pairs, n_pairs;
    logic [63:0] r_varint_acc, n_varint_acc;
    logic [63:0] r_pending_type, n_pending_type;
    logic [31:0] r_consumed, n_consumed;

    logic [7:0]  w_b;
    logic        w_eod;
    logic [31:0] w_consumed_inc;
    logic [1:0]  w_len_m1;
    logic [31:0] w_word_new;
    logic [6:0]  w_shamt;
    logic [63:0] w_varint_new;
    logic [31:0] w_pairs_dec;
    vhp_pkg::t_qwrite w_wr;

    function automatic vhp_pkg::t_result mk_error(input vhp_pkg::t_err code);
        vhp_pkg::t_result r;
        r                = '0;
        r.result_kind    = vhp_pkg::KIND_ERROR;
        r.error_code     = code;
        r.last_of_header = 1'b1;
        return r;
    endfunction

    function automatic vhp_pkg::t_result mk_done(input logic [31:0] len);
        vhp_pkg::t_result r;
        r                = '0;
        r.result_kind    = vhp_pkg::KIND_DONE;
        r.header_length  = len;
        r.last_of_header = 1'b1;
        return r;
    endfunction

    always_comb begin
        n_phase        = r_phase;
        n_group_key    = r_group_key;
        n_value_index  = r_value_index;
        n_byte_index   = r_byte_index;
        n_word_acc     = r_word_acc;
        n_body_size    = r_body_size;
        n_type_id      = r_type_id;
        n_request_id   = r_request_id;
        n_pairs        = r_pairs;
        n_varint_acc   = r_varint_acc;
        n_pending_type = r_pending_type;
        n_consumed     = r_consumed;
        w_wr           = '0;

        w_b            = i_in.data_byte;
        w_eod          = i_in.end_of_data;
        w_consumed_inc = (r_consumed == '1) ? r_consumed : r_consumed + 32'd1;
        w_len_m1       = 2'(r_group_key >> {r_value_index, 1'b0});
        w_word_new     = r_word_acc | ({24'b0, w_b} << {r_byte_index[1:0], 3'b000});
        w_shamt        = 7'({3'b0, r_byte_index} * 7'd7);
        w_varint_new   = (r_byte_index <= vhp_pkg::VARINT_LAST_FULL)
                       ? (r_varint_acc | ({57'b0, w_b[6:0]} << w_shamt))
                       : (r_varint_acc | {w_b[0], 63'b0});
        w_pairs_dec    = r_pairs - 32'd1;

        if (i_valid) begin
            case (r_phase)
                vhp_pkg::PH_MAGIC: begin
                    n_consumed = 32'd1;
                    if (w_eod) begin
                        w_wr.wr0  = 1'b1;
                        w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                    end else if (w_b != r_magic) begin
                        w_wr.wr0  = 1'b1;
                        w_wr.res0 = mk_error(vhp_pkg::ERR_MAGIC);
                        n_phase   = vhp_pkg::PH_SKIP;
                    end else begin
                        n_phase = vhp_pkg::PH_KEY;
                    end
                end
                vhp_pkg::PH_SKIP: begin
                    if (w_eod) begin
                        n_phase = vhp_pkg::PH_MAGIC;
                    end
                end
                vhp_pkg::PH_KEY: begin
                    n_consumed = w_consumed_inc;
                    if (w_eod) begin
                        w_wr.wr0  = 1'b1;
                        w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                        n_phase   = vhp_pkg::PH_MAGIC;
                    end else begin
                        n_group_key   = w_b;
                        n_value_index = '0;
                        n_byte_index  = '0;
                        n_word_acc    = '0;
                        n_phase       = vhp_pkg::PH_GROUP;
                    end
                end
                vhp_pkg::PH_GROUP: begin
                    n_consumed = w_consumed_inc;
                    if (r_byte_index >= {2'b0, w_len_m1}) begin
                        n_word_acc   = '0;
                        n_byte_index = '0;
                        case (r_value_index)
                            2'd0:    n_body_size  = w_word_new;
                            2'd1:    n_type_id    = w_word_new;
                            2'd2:    n_request_id = w_word_new;
                            default: n_pairs      = w_word_new;
                        endcase
                        if (r_value_index == 2'd3) begin
                            w_wr.wr0              = 1'b1;
                            w_wr.res0             = '0;
                            w_wr.res0.result_kind = vhp_pkg::KIND_BASE;
                            w_wr.res0.body_size   = r_body_size;
                            w_wr.res0.type_id     = r_type_id;
                            w_wr.res0.request_id  = r_request_id;
                            w_wr.res0.extra_count = w_word_new;
                            w_wr.wr1              = 1'b1;
                            if (w_word_new == '0) begin
                                w_wr.res1 = mk_done(w_consumed_inc);
                                n_phase   = w_eod ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_SKIP;
                            end else if (w_eod) begin
                                w_wr.res1 = mk_error(vhp_pkg::ERR_SHORT);
                                n_phase   = vhp_pkg::PH_MAGIC;
                            end else begin
                                w_wr.wr1     = 1'b0;
                                n_varint_acc = '0;
                                n_phase      = vhp_pkg::PH_PTYPE;
                            end
                        end else begin
                            n_value_index = r_value_index + 2'd1;
                            if (w_eod) begin
                                w_wr.wr0  = 1'b1;
                                w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                                n_phase   = vhp_pkg::PH_MAGIC;
                            end
                        end
                    end else begin
                        n_word_acc   = w_word_new;
                        n_byte_index = r_byte_index + 4'd1;
                        if (w_eod) begin
                            w_wr.wr0  = 1'b1;
                            w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                            n_phase   = vhp_pkg::PH_MAGIC;
                        end
                    end
                end
                vhp_pkg::PH_PTYPE, vhp_pkg::PH_PVALUE: begin
                    n_consumed   = w_consumed_inc;
                    n_varint_acc = w_varint_new;
                    if (w_b[7]) begin
                        if (r_byte_index > vhp_pkg::VARINT_LAST_FULL) begin
                            // continuation on the tenth byte: varint too long
                            w_wr.wr0  = 1'b1;
                            w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                            n_phase   = w_eod ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_SKIP;
                        end else begin
                            n_byte_index = r_byte_index + 4'd1;
                            if (w_eod) begin
                                w_wr.wr0  = 1'b1;
                                w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                                n_phase   = vhp_pkg::PH_MAGIC;
                            end
                        end
                    end else if (r_phase == vhp_pkg::PH_PTYPE) begin
                        n_pending_type = w_varint_new;
                        n_byte_index   = '0;
                        n_varint_acc   = '0;
                        n_phase        = vhp_pkg::PH_PVALUE;
                        if (w_eod) begin
                            w_wr.wr0  = 1'b1;
                            w_wr.res0 = mk_error(vhp_pkg::ERR_SHORT);
                            n_phase   = vhp_pkg::PH_MAGIC;
                        end
                    end else begin
                        w_wr.wr0              = 1'b1;
                        w_wr.res0             = '0;
                        w_wr.res0.result_kind = vhp_pkg::KIND_PAIR;
                        w_wr.res0.pair_type   = r_pending_type;
                        w_wr.res0.pair_value  = w_varint_new;
                        w_wr.res0.pair_known  = (r_pending_type <= {56'b0, r_hkt});
                        n_pairs               = w_pairs_dec;
                        w_wr.wr1              = 1'b1;
                        if (w_pairs_dec == '0) begin
                            w_wr.res1 = mk_done(w_consumed_inc);
                            n_phase   = w_eod ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_SKIP;
                        end else if (w_eod) begin
                            w_wr.res1 = mk_error(vhp_pkg::ERR_SHORT);
                            n_phase   = vhp_pkg::PH_MAGIC;
                        end else begin
                            w_wr.wr1     = 1'b0;
                            n_byte_index = '0;
                            n_varint_acc = '0;
                            n_phase      = vhp_pkg::PH_PTYPE;
                        end
                    end
                end
                default: begin
                    n_phase = vhp_pkg::PH_MAGIC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= vhp_pkg::PH_MAGIC;
            r_group_key    <= '0;
            r_value_index  <= '0;
            r_byte_index   <= '0;
            r_word_acc     <= '0;
            r_body_size    <= '0;
            r_type_id      <= '0;
            r_request_id   <= '0;
            r_pairs        <= '0;
            r_varint_acc   <= '0;
            r_pending_type <= '0;
            r_consumed     <= '0;
        end else begin
            r_phase        <= n_phase;
            r_group_key    <= n_group_key;
            r_value_index  <= n_value_index;
            r_byte_index   <= n_byte_index;
            r_word_acc     <= n_word_acc;
            r_body_size    <= n_body_size;
            r_type_id      <= n_type_id;
            r_request_id   <= n_request_id;
            r_pairs        <= n_pairs;
            r_varint_acc   <= n_varint_acc;
            r_pending_type <= n_pending_type;
            r_consumed     <= n_consumed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= vhp_pkg::MAGIC_RESET;
            r_hkt   <= vhp_pkg::HKT_RESET;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                vhp_pkg::CFG_MAGIC_VALUE:        r_magic <= i_cfg.data;
                vhp_pkg::CFG_HIGHEST_KNOWN_TYPE: r_hkt   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign o_wr = w_wr;

endmodule
`default_nettype wire

// ===== sv/varint_header_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// results: the results of a byte enter the result queue as the byte is taken
// throughput: one byte per cycle, up to two results per byte; the byte parser only waits
//   when the result queue has fewer than two free entries
// reset: synchronous active low; parser back to waiting for magic, registers to 94 and 7,
//   result queue empty
module varint_header_parser #(
    parameter int DEPTH = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request side
    input  wire logic                             push,
    output logic                                  full,
    input  wire vhp_pkg::t_in                     i_in,
    // result side
    output logic                                  empty,
    input  wire logic                             pop,
    output vhp_pkg::t_result                      o_res,
    // register writes
    input  wire logic                             i_cfg_we,
    input  wire logic [vhp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [vhp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic             w_room2;
    logic             w_accept;
    vhp_pkg::t_cfg_wr w_cfg;
    vhp_pkg::t_qwrite w_qwr;

    // a request is taken only when the queue can absorb the worst case of two results
    assign full     = !w_room2;
    assign w_accept = push && !full;

    always_comb begin
        w_cfg.we   = i_cfg_we;
        w_cfg.idx  = i_cfg_idx;
        w_cfg.data = i_cfg_data;
    end

    // front: byte classification, field assembly and result building
    vhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .o_wr    (w_qwr)
    );

    // back: result queue, drained one result per pop
    vhp_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_qwr),
        .i_pop   (pop),
        .o_empty (empty),
        .o_room2 (w_room2),
        .o_head  (o_res)
    );

endmodule
`default_nettype wire

// ===== sv/vhp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "varint_header_parser_macros.svh"
module vhp_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             full,
    input wire logic             empty,
    input wire logic             pop,
    input wire vhp_pkg::t_result o_res
);

    logic w_term;
    logic w_is_err;

    assign w_term   = (o_res.result_kind == vhp_pkg::KIND_DONE)
                   || (o_res.result_kind == vhp_pkg::KIND_ERROR);
    assign w_is_err = (o_res.result_kind == vhp_pkg::KIND_ERROR);

    // queue comes out of reset empty and open
    `VHP_ASSERT_NXT(a_reset_clean, i_clk, 1'b1, !i_rst_n, empty && !full)

    // only completion and error close a header
    `VHP_ASSERT_IMP(a_last_matches_kind, i_clk, i_rst_n, !empty, o_res.last_of_header == w_term)

    // an error code shows exactly on error results
    `VHP_ASSERT_IMP(a_code_matches_kind, i_clk, i_rst_n, !empty,
                    w_is_err == (o_res.error_code != vhp_pkg::ERR_NONE))

    // a waiting result holds until taken
    `VHP_ASSERT_NXT(a_head_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_res))

endmodule

bind varint_header_parser vhp_checker u_vhp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_res   (o_res)
);
`default_nettype wire

// ===== bench/tb_varint_header_parser.sv =====
`timescale 1ns / 1ps
module tb_varint_header_parser;

    // clock, reset and block ports
    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           req_push = 1'b0;
    logic                           req_full;
    vhp_pkg::t_in                   req_item = '0;
    logic                           res_empty;
    logic                           res_pop  = 1'b0;
    vhp_pkg::t_result               res_item;
    logic                           cfg_we   = 1'b0;
    logic [vhp_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [vhp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    varint_header_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (req_push),
        .full       (req_full),
        .i_in       (req_item),
        .empty      (res_empty),
        .pop        (res_pop),
        .o_res      (res_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // parser state mirror: register copies and the byte-level state
    // ------------------------------------------------------------------
    logic [7:0]      cfg_magic;
    logic [7:0]      cfg_hkt;
    vhp_pkg::t_phase ph;
    logic [7:0]      grp_key;
    logic [1:0]      val_idx;
    logic [3:0]      byte_idx;
    logic [31:0]     word_acc;
    logic [31:0]     body_sz;
    logic [31:0]     type_sv;
    logic [31:0]     req_sv;
    logic [31:0]     pairs_left;
    logic [63:0]     vacc;
    logic [63:0]     ptype;
    logic [31:0]     consumed;

    // results the parser owes us, oldest first
    vhp_pkg::t_result predicted_results[$];
    int               mismatch_count = 0;

    // sender and receiver pacing
    int          bytes_sent = 0;
    int          tx_burst_left = 0;
    bit          tx_steady = 1'b0;
    int          hold_req = 0;

    // bytes of the request stream being assembled
    logic [7:0]  frame[$];

    function automatic void reset_model();
        cfg_magic  = vhp_pkg::MAGIC_RESET;
        cfg_hkt    = vhp_pkg::HKT_RESET;
        ph         = vhp_pkg::PH_MAGIC;
        grp_key    = '0;
        val_idx    = '0;
        byte_idx   = '0;
        word_acc   = '0;
        body_sz    = '0;
        type_sv    = '0;
        req_sv     = '0;
        pairs_left = '0;
        vacc       = '0;
        ptype      = '0;
        consumed   = '0;
    endfunction

    // error ends the header; without end of data the rest of the buffer is skipped
    function automatic void post_error(vhp_pkg::t_err code, logic eod);
        vhp_pkg::t_result r;
        r = '0;
        r.result_kind    = vhp_pkg::KIND_ERROR;
        r.error_code     = code;
        r.last_of_header = 1'b1;
        predicted_results.push_back(r);
        ph = eod ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_SKIP;
    endfunction

    function automatic void post_done(logic eod);
        vhp_pkg::t_result r;
        r = '0;
        r.result_kind    = vhp_pkg::KIND_DONE;
        r.header_length  = consumed;
        r.last_of_header = 1'b1;
        predicted_results.push_back(r);
        ph = eod ? vhp_pkg::PH_MAGIC : vhp_pkg::PH_SKIP;
    endfunction

    function automatic void start_varint(vhp_pkg::t_phase next);
        ph       = next;
        byte_idx = '0;
        vacc     = '0;
    endfunction

    // advance the mirror by one accepted byte, queueing what it produces
    function automatic void predict_byte(logic [7:0] b, logic eod);
        int               len;
        logic [31:0]      v;
        vhp_pkg::t_result r;
        if (ph == vhp_pkg::PH_MAGIC) begin
            consumed = 32'd1;
            if (eod) begin
                // a lone byte is short data, magic or not
                post_error(vhp_pkg::ERR_SHORT, 1'b1);
            end else if (b != cfg_magic) begin
                post_error(vhp_pkg::ERR_MAGIC, 1'b0);
            end else begin
                ph = vhp_pkg::PH_KEY;
            end
            return;
        end
        if (ph == vhp_pkg::PH_SKIP) begin
            if (eod) begin
                ph = vhp_pkg::PH_MAGIC;
            end
            return;
        end
        if (consumed != 32'hFFFF_FFFF) begin
            consumed++;
        end
        case (ph)
            vhp_pkg::PH_KEY: begin
                if (eod) begin
                    post_error(vhp_pkg::ERR_SHORT, 1'b1);
                end else begin
                    grp_key  = b;
                    val_idx  = '0;
                    byte_idx = '0;
                    word_acc = '0;
                    ph       = vhp_pkg::PH_GROUP;
                end
            end
            vhp_pkg::PH_GROUP: begin
                len = int'((grp_key >> (2 * val_idx)) & 8'd3) + 1;
                word_acc |= 32'(b) << (8 * byte_idx[1:0]);
                byte_idx++;
                if (byte_idx >= len) begin
                    v        = word_acc;
                    word_acc = '0;
                    byte_idx = '0;
                    case (val_idx)
                        2'd0: body_sz = v;
                        2'd1: type_sv = v;
                        2'd2: req_sv = v;
                        default: pairs_left = v;
                    endcase
                    if (val_idx == 2'd3) begin
                        // group block complete: report the base fields
                        r = '0;
                        r.result_kind = vhp_pkg::KIND_BASE;
                        r.body_size   = body_sz;
                        r.type_id     = type_sv;
                        r.request_id  = req_sv;
                        r.extra_count = pairs_left;
                        predicted_results.push_back(r);
                        if (pairs_left == 0) begin
                            post_done(eod);
                        end else begin
                            start_varint(vhp_pkg::PH_PTYPE);
                            if (eod) begin
                                post_error(vhp_pkg::ERR_SHORT, 1'b1);
                            end
                        end
                        return;
                    end
                    val_idx++;
                end
                if (eod) begin
                    post_error(vhp_pkg::ERR_SHORT, 1'b1);
                end
            end
            default: begin
                // leb128 byte of a pair type or value; the tenth byte adds bit 63 only
                if (byte_idx < 9) begin
                    vacc |= 64'(b & 8'h7F) << (7 * byte_idx);
                end else begin
                    vacc[63] = vacc[63] | b[0];
                end
                if (b[7]) begin
                    if (byte_idx >= 9) begin
                        post_error(vhp_pkg::ERR_SHORT, eod);
                    end else begin
                        byte_idx++;
                        if (eod) begin
                            post_error(vhp_pkg::ERR_SHORT, 1'b1);
                        end
                    end
                end else if (ph == vhp_pkg::PH_PTYPE) begin
                    ptype = vacc;
                    start_varint(vhp_pkg::PH_PVALUE);
                    if (eod) begin
                        post_error(vhp_pkg::ERR_SHORT, 1'b1);
                    end
                end else begin
                    r = '0;
                    r.result_kind = vhp_pkg::KIND_PAIR;
                    r.pair_type   = ptype;
                    r.pair_value  = vacc;
                    r.pair_known  = (ptype <= 64'(cfg_hkt));
                    predicted_results.push_back(r);
                    pairs_left--;
                    if (pairs_left == 0) begin
                        post_done(eod);
                    end else begin
                        start_varint(vhp_pkg::PH_PTYPE);
                        if (eod) begin
                            post_error(vhp_pkg::ERR_SHORT, 1'b1);
                        end
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    function automatic void check_result(vhp_pkg::t_result got);
        vhp_pkg::t_result want;
        if (predicted_results.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
            return;
        end
        want = predicted_results.pop_front();
        check_field("result_kind", want.result_kind, got.result_kind);
        check_field("body_size", want.body_size, got.body_size);
        check_field("type_id", want.type_id, got.type_id);
        check_field("request_id", want.request_id, got.request_id);
        check_field("extra_count", want.extra_count, got.extra_count);
        check_field("pair_type", want.pair_type, got.pair_type);
        check_field("pair_value", want.pair_value, got.pair_value);
        check_field("pair_known", want.pair_known, got.pair_known);
        check_field("header_length", want.header_length, got.header_length);
        check_field("error_code", want.error_code, got.error_code);
        check_field("last_of_header", want.last_of_header, got.last_of_header);
    endfunction

    // result side: samples at each edge, then picks the next pop;
    // runs its own stall pattern and honors long hold-off requests
    initial begin : result_side
        int mode;
        int mode_left;
        int hold_left;
        int beat;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        beat      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_pop && res_empty === 1'b0) begin
                check_result(res_item);
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 512);
            end
            mode_left--;
            beat++;
            if (hold_left > 0) begin
                hold_left--;
                res_pop <= 1'b0;
            end else begin
                case (mode)
                    0: res_pop <= 1'b1;
                    1: res_pop <= ($urandom_range(0, 3) != 0);
                    2: res_pop <= ((beat % 5) >= 2);
                    default: res_pop <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one byte and hold it until the parser takes it; bursts with gaps unless tx_steady is set
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        if (!tx_steady && tx_burst_left <= 0) begin
            tx_burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        req_push <= 1'b1;
        req_item <= vhp_pkg::t_in'{data_byte: b, end_of_data: eod};
        do @(posedge i_clk); while (req_full !== 1'b0);
        bytes_sent++;
        predict_byte(b, eod);
    endtask

    // send the assembled frame, flagging its final byte as end of data
    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) begin
            send_byte(frame[i], i == frame.size() - 1);
        end
        frame.delete();
    endtask

    // stop offering and let the parser drain completely
    task automatic wait_idle();
        req_push <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vhp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == vhp_pkg::CFG_MAGIC_VALUE) begin
            cfg_magic = value;
        end else begin
            cfg_hkt = value;
        end
    endtask

    // ------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // small codes straddle the known limit; some span the full 64 bits
    function automatic logic [63:0] rand_type();
        case ($urandom_range(0, 3))
            0, 1: return 64'($urandom_range(0, 15));
            2: return 64'($urandom_range(0, 300));
            default: return rand_wide();
        endcase
    endfunction

    function automatic int group_len(logic [31:0] v);
        if (v[31:24] != 0) begin
            return 4;
        end
        if (v[23:16] != 0) begin
            return 3;
        end
        if (v[15:8] != 0) begin
            return 2;
        end
        return 1;
    endfunction

    // leb128, sometimes padded with zero groups up to the ten-byte limit
    function automatic void put_leb(logic [63:0] v);
        int         n;
        logic [7:0] b;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0) n++;
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(n, 10);
        end
        for (int i = 0; i < n; i++) begin
            if (i < 9) begin
                b = 8'(v >> (7 * i)) & 8'h7F;
                if (i < n - 1) begin
                    b[7] = 1'b1;
                end
            end else begin
                // tenth byte: only bit 0 counts, the middle bits are noise
                b = {1'b0, 6'($urandom), v[63]};
            end
            frame.push_back(b);
        end
    endfunction

    function automatic void add_junk(int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    // magic, key byte with random lengths, four group values, npairs pairs
    function automatic void build_header(logic [7:0] magic, int npairs, logic [31:0] count);
        logic [31:0] vals[4];
        int          lens[4];
        logic [7:0]  key;
        vals[0] = rand_word();
        vals[1] = rand_word();
        vals[2] = rand_word();
        vals[3] = count;
        key = '0;
        for (int k = 0; k < 4; k++) begin
            lens[k] = $urandom_range(group_len(vals[k]), 4);
            key |= 8'(lens[k] - 1) << (2 * k);
        end
        frame.push_back(magic);
        frame.push_back(key);
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < lens[k]; j++) begin
                frame.push_back(vals[k][8 * j +: 8]);
            end
        end
        for (int p = 0; p < npairs; p++) begin
            put_leb(rand_type());
            put_leb(rand_wide());
        end
    endfunction

    // one random request stream, mostly well-formed headers
    task automatic random_frame();
        int pick;
        int n;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            n = $urandom_range(0, 4);
            build_header(cfg_magic, n, 32'(n));
            if ($urandom_range(0, 9) == 0) begin
                // cut short anywhere
                cut = $urandom_range(1, frame.size());
                while (frame.size() > cut) void'(frame.pop_back());
            end else if ($urandom_range(0, 1) == 0) begin
                // trailing bytes after the header get skipped
                add_junk($urandom_range(1, 4));
            end
        end else if (pick < 72) begin
            // announced count rarely matches the pairs that follow
            n = $urandom_range(0, 3);
            build_header(cfg_magic, n, rand_word());
        end else if (pick < 80) begin
            // varint that never terminates within ten bytes
            n = $urandom_range(0, 1);
            build_header(cfg_magic, n, 32'($urandom_range(n + 1, 3)));
            if ($urandom_range(0, 1) == 0) begin
                put_leb(rand_type());
            end
            repeat (10) frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
            if ($urandom_range(0, 1) == 0) begin
                add_junk($urandom_range(1, 3));
            end
        end else if (pick < 88) begin
            frame.push_back(cfg_magic ^ 8'($urandom_range(1, 255)));
            add_junk($urandom_range(0, 3));
        end else if (pick < 93) begin
            frame.push_back(8'($urandom));
        end else begin
            add_junk($urandom_range(1, 12));
        end
        send_frame();
    endtask

    task automatic run_frames(int nbytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) random_frame();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // single byte flagged end of data: short data whether it matches or not
    task automatic test_lone_byte();
        send_byte(cfg_magic, 1'b1);
        send_byte(cfg_magic ^ 8'h01, 1'b1);
    endtask

    // wrong first byte, then the rest of the buffer is ignored
    task automatic test_bad_magic();
        frame = '{~cfg_magic, cfg_magic, 8'hFF};
        send_frame();
    endtask

    // buffer ends inside the group block, then inside a pair type
    task automatic test_early_end();
        frame = '{cfg_magic, 8'hE4, 8'h11};
        send_frame();
        frame = '{cfg_magic, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h03, 8'h85};
        send_frame();
    endtask

    // tenth varint byte still has its continuation bit
    task automatic test_long_varint();
        frame = '{cfg_magic, 8'h00, 8'h01, 8'h02, 8'h03, 8'h01};
        repeat (10) frame.push_back(8'hFF);
        frame.push_back(8'h00);
        send_frame();
    endtask

    // one pair right at the known limit, one just above it
    task automatic test_pair_known_flag();
        frame = '{cfg_magic, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                  cfg_hkt, 8'h7F, 8'(cfg_hkt + 8'd1), 8'h00};
        send_frame();
    endtask

    task automatic test_random_frames();
        run_frames(650);
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_full_stall();
        tx_steady = 1'b1;
        hold_req  = 300;
        repeat (6) begin
            build_header(cfg_magic, 3, 32'd3);
            send_frame();
        end
        tx_steady = 1'b0;
    endtask

    // extremes, random values, then back to the reset values
    task automatic test_register_settings();
        logic [7:0] magic;
        logic [7:0] limit;
        for (int k = 0; k < 5; k++) begin
            case (k)
                0: begin
                    magic = 8'h00;
                    limit = 8'h00;
                end
                1: begin
                    magic = 8'hFF;
                    limit = 8'hFF;
                end
                4: begin
                    magic = vhp_pkg::MAGIC_RESET;
                    limit = vhp_pkg::HKT_RESET;
                end
                default: begin
                    magic = 8'($urandom);
                    limit = 8'($urandom_range(0, 20));
                end
            endcase
            write_reg(vhp_pkg::CFG_MAGIC_VALUE, magic);
            write_reg(vhp_pkg::CFG_HIGHEST_KNOWN_TYPE, limit);
            run_frames(170);
        end
    endtask

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lone_byte();
        test_bad_magic();
        test_early_end();
        test_long_varint();
        test_pair_known_flag();
        test_random_frames();
        test_full_stall();
        test_register_settings();

        // drain, then give any stray result time to show up
        req_push <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/vhp_pkg.sv
sv/vhp_queue.sv
sv/vhp_front.sv
sv/varint_header_parser.sv
sv/vhp_checker.sv
bench/tb_varint_header_parser.sv
